[rtl/core/key_short_long_press_classifier_defines.svh]
// Assertion macros shared by the key press classifier RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef KEY_SHORT_LONG_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_SHORT_LONG_PRESS_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSLP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kslp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KSLP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kslp assertion failed");

`endif

[rtl/core/kslp_pkg.sv]
// Package for the key short/long press classifier.
// Holds the configuration struct, register indexes, reset values and lane status type.
package kslp_pkg;

	localparam int CFG_BITS   = 16;
	localparam int LEVEL_BITS = 4;
	localparam int QUERY_BITS = 8;
	localparam int MASK_BITS  = 4;
	localparam int MODE_BITS  = 2;

	typedef enum logic [1:0] {
		REG_SHORT_THRESHOLD = 2'd0,
		REG_LONG_THRESHOLD  = 2'd1,
		REG_COUNT_LIMIT     = 2'd2
	} reg_index_t;

	localparam logic [CFG_BITS-1:0] SHORT_THRESHOLD_RST = 16'd1;
	localparam logic [CFG_BITS-1:0] LONG_THRESHOLD_RST  = 16'd10;
	localparam logic [CFG_BITS-1:0] COUNT_LIMIT_RST     = 16'd100;

	typedef struct packed {
		logic [CFG_BITS-1:0] short_threshold;
		logic [CFG_BITS-1:0] long_threshold;
		logic [CFG_BITS-1:0] count_limit;
	} cfg_t;

	typedef struct packed {
		logic short_hit;
		logic long_hit;
		logic over_short;
		logic over_long;
	} lane_stat_t;

endpackage

[rtl/core/kslp_lane.sv]
// Per-key counter lane: run and press counters with saturation and classification.
// Depends on kslp_pkg for the configuration and lane status types.
module kslp_lane #(
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                held,
	input  logic                any_held,
	input  kslp_pkg::cfg_t      cfg,
	output kslp_pkg::lane_stat_t stat
);

	localparam int CMP_BITS = (COUNT_BITS > kslp_pkg::CFG_BITS) ? COUNT_BITS : kslp_pkg::CFG_BITS;

	logic [COUNT_BITS-1:0] run_q;
	logic [COUNT_BITS-1:0] press_q;
	logic [COUNT_BITS-1:0] run_bump;
	logic [COUNT_BITS-1:0] press_bump;
	logic [COUNT_BITS-1:0] run_next;
	logic [COUNT_BITS-1:0] press_next;
	logic [CMP_BITS-1:0]   press_x;
	logic [CMP_BITS-1:0]   run_x;
	logic [CMP_BITS-1:0]   st_x;
	logic [CMP_BITS-1:0]   lt_x;
	logic [CMP_BITS-1:0]   lim_x;

	assign run_bump   = (&run_q) ? run_q : run_q + COUNT_BITS'(1);
	assign press_bump = (&press_q) ? press_q : press_q + COUNT_BITS'(1);

	always_comb begin
		run_next   = run_q;
		press_next = press_q;
		if (en) begin
			if (held) begin
				run_next   = run_bump;
				press_next = press_bump;
			end else begin
				run_next = '0;
				if (!any_held) begin
					press_next = '0;
				end
			end
		end
	end

	assign press_x = CMP_BITS'(press_q);
	assign run_x   = CMP_BITS'(run_next);
	assign st_x    = CMP_BITS'(cfg.short_threshold);
	assign lt_x    = CMP_BITS'(cfg.long_threshold);
	assign lim_x   = CMP_BITS'(cfg.count_limit);

	assign stat.short_hit  = (press_x > st_x) && (press_x < lt_x);
	assign stat.long_hit   = (press_x > lt_x) && (press_x < lim_x);
	assign stat.over_short = run_x > st_x;
	assign stat.over_long  = run_x > lt_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			press_q <= '0;
		end else begin
			run_q   <= run_next;
			press_q <= press_next;
		end
	end

endmodule

[rtl/core/key_short_long_press_classifier.sv]
// Key short/long press classifier, top level.
// An accepted transaction is held in the input register, and its result then in the output register.
// Throughput: one transaction per cycle; while a result is stalled the input register
// takes one more transaction and then in_stall rises.
// Reset: arst_n clears counters, latched masks, valids and restores config defaults.
// Depends on kslp_pkg, kslp_lane and key_short_long_press_classifier_defines.svh.
`include "key_short_long_press_classifier_defines.svh"

module key_short_long_press_classifier #(
	parameter int NUM_KEYS   = 4,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                tick,
	input  logic [kslp_pkg::LEVEL_BITS-1:0]     key_levels,
	input  logic                                clear_short,
	input  logic                                clear_long,
	input  logic [kslp_pkg::QUERY_BITS-1:0]     query_keys,
	input  logic [kslp_pkg::MODE_BITS-1:0]      query_mode,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                held_match,
	output logic                                latched_match,
	output logic [kslp_pkg::MASK_BITS-1:0]      short_mask,
	output logic [kslp_pkg::MASK_BITS-1:0]      long_mask,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [kslp_pkg::CFG_BITS-1:0]       cfg_data
);

	kslp_pkg::cfg_t cfg_q;

	logic                                s1_valid_q;
	logic                                tick_s1;
	logic [kslp_pkg::LEVEL_BITS-1:0]     levels_s1;
	logic                                clr_s_s1;
	logic                                clr_l_s1;
	logic [kslp_pkg::QUERY_BITS-1:0]     qkeys_s1;
	logic [kslp_pkg::MODE_BITS-1:0]      qmode_s1;

	logic                                out_valid_q;
	logic                                held_match_s2;
	logic                                latched_match_s2;

	logic [NUM_KEYS-1:0]                 short_q;
	logic [NUM_KEYS-1:0]                 long_q;
	logic [NUM_KEYS-1:0]                 short_next;
	logic [NUM_KEYS-1:0]                 long_next;

	logic                                adv;
	logic [NUM_KEYS-1:0]                 lvl;
	logic [NUM_KEYS-1:0]                 short_hits;
	logic [NUM_KEYS-1:0]                 long_hits;
	logic [NUM_KEYS-1:0]                 over_short;
	logic [NUM_KEYS-1:0]                 over_long;
	logic [NUM_KEYS-1:0]                 held_set;
	logic                                any_held;
	logic                                held_eq;
	logic                                latched_eq;

	kslp_pkg::lane_stat_t lane_stat [NUM_KEYS];

	assign adv       = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !adv;
	assign cfg_ready = 1'b1;

	genvar k;
	generate
		for (k = 0; k < NUM_KEYS; k++) begin : g_key
			if (k < kslp_pkg::LEVEL_BITS) begin : g_pin
				assign lvl[k] = levels_s1[k];
			end else begin : g_nopin
				assign lvl[k] = 1'b1;
			end

			kslp_lane #(
				.COUNT_BITS(COUNT_BITS)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (adv && tick_s1),
				.held     (!lvl[k]),
				.any_held (any_held),
				.cfg      (cfg_q),
				.stat     (lane_stat[k])
			);

			assign short_hits[k] = lane_stat[k].short_hit;
			assign long_hits[k]  = lane_stat[k].long_hit;
			assign over_short[k] = lane_stat[k].over_short;
			assign over_long[k]  = lane_stat[k].over_long;
		end

		for (k = 0; k < kslp_pkg::MASK_BITS; k++) begin : g_mask
			if (k < NUM_KEYS) begin : g_used
				assign short_mask[k] = short_q[k];
				assign long_mask[k]  = long_q[k];
			end else begin : g_unused
				assign short_mask[k] = 1'b0;
				assign long_mask[k]  = 1'b0;
			end
		end
	endgenerate

	assign any_held = tick_s1 && (~lvl != '0);

	always_comb begin
		short_next = short_q;
		long_next  = long_q;
		if (tick_s1) begin
			if (any_held) begin
				short_next = '0;
				long_next  = '0;
			end else begin
				short_next = short_q | short_hits;
				long_next  = long_q | long_hits;
			end
		end
		if (clr_s_s1) begin
			short_next = '0;
		end
		if (clr_l_s1) begin
			long_next = '0;
		end
	end

	always_comb begin
		priority if (qmode_s1[0]) begin
			held_set   = qkeys_s1[NUM_KEYS-1:0] & over_short;
			latched_eq = kslp_pkg::QUERY_BITS'(short_next) == qkeys_s1;
		end else if (qmode_s1[1]) begin
			held_set   = qkeys_s1[NUM_KEYS-1:0] & over_long;
			latched_eq = kslp_pkg::QUERY_BITS'(long_next) == qkeys_s1;
		end else begin
			held_set   = '0;
			latched_eq = 1'b0;
		end
	end

	assign held_eq = kslp_pkg::QUERY_BITS'(held_set) == qkeys_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_threshold <= kslp_pkg::SHORT_THRESHOLD_RST;
			cfg_q.long_threshold  <= kslp_pkg::LONG_THRESHOLD_RST;
			cfg_q.count_limit     <= kslp_pkg::COUNT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kslp_pkg::REG_SHORT_THRESHOLD: cfg_q.short_threshold <= cfg_data;
				kslp_pkg::REG_LONG_THRESHOLD:  cfg_q.long_threshold  <= cfg_data;
				kslp_pkg::REG_COUNT_LIMIT:     cfg_q.count_limit     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			short_q     <= '0;
			long_q      <= '0;
		end else begin
			if (!s1_valid_q || adv) begin
				s1_valid_q <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				short_q     <= short_next;
				long_q      <= long_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1   <= tick;
			levels_s1 <= key_levels;
			clr_s_s1  <= clear_short;
			clr_l_s1  <= clear_long;
			qkeys_s1  <= query_keys;
			qmode_s1  <= query_mode;
		end
		if (adv) begin
			held_match_s2    <= held_eq;
			latched_match_s2 <= latched_eq;
		end
	end

	assign out_valid     = out_valid_q;
	assign held_match    = held_match_s2;
	assign latched_match = latched_match_s2;

	`KSLP_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_q)
	`KSLP_ASSERT_IMP(a_no_adv_on_stall, out_valid_q && out_stall, !adv)
	`KSLP_ASSERT_NXT(a_held_clears_masks, adv && any_held, short_q == '0 && long_q == '0)
	`KSLP_ASSERT_NXT(a_masks_hold_idle, !adv, $stable(short_q) && $stable(long_q))

endmodule
